/* hw/rtl/i2cee_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// I2C EEPROM slave unit. No dependencies.
package i2cee_pkg;

   localparam int MEM_BYTES = 8192;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int WORD_W    = 13;
   localparam int DATA_W    = 8;

   localparam logic [WORD_W-1:0] MASK_RESET    = 13'd2047;
   localparam logic [WORD_W-1:0] ONE_BYTE_MAX  = 13'd2047;
   localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

   typedef enum logic [1:0] {
      OP_PIN  = 2'd0,
      OP_DIR  = 2'd1,
      OP_READ = 2'd2,
      OP_LOAD = 2'd3
   } opcode_type;

   localparam logic [1:0] PH_DEVICE = 2'd0;
   localparam logic [1:0] PH_WORD   = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;
   localparam logic [1:0] PH_LOW    = 2'd3;

   typedef struct packed {
      logic clear;
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctrl_status_type;

   function automatic logic [ADDR_W-1:0] mem_index(input logic [WORD_W-1:0] addr,
                                                   input logic [WORD_W-1:0] mask);
      logic [31:0] wide;
      wide = {{(32-WORD_W){1'b0}}, addr & mask};
      return wide[ADDR_W-1:0];
   endfunction

endpackage

/* hw/rtl/i2c_eeprom_slave_unit.sv */
// Top level of the I2C EEPROM slave unit: controller, datapath and byte store.
// Depends on i2cee_pkg, i2cee_ram, i2cee_ctrl and i2cee_datapath.
//
// After reset the unit erases its 8192-byte store to 0xFF in a sweep of one
// byte a cycle, holding busy high; address mask writes are taken throughout.
// Afterwards each item passes through the accept, a fetch state for the
// registered store read at the current word address, and an execute state
// for the state update and any store write. Its result is strobed on
// rsp_valid in the following cycle, the same cycle in which busy is low and
// the next item may be accepted.
// Results cannot be held off and must be taken in the cycle they appear.
module i2c_eeprom_slave_unit import i2cee_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic                req_scl_level,
   input  logic                req_sda_level,
   input  logic                req_drive_sda,
   input  logic [WORD_W-1:0]   req_load_address,
   input  logic [DATA_W-1:0]   req_load_data,
   output logic                rsp_valid,
   output logic                rsp_sda_line,
   output logic                rsp_scl_echo,
   output logic                rsp_byte_stored,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WORD_W-1:0]   csr_address_mask
);

   ctrl_cmd_type      cmd;
   ctrl_status_type   status;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   i2cee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   i2cee_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_scl_level    (req_scl_level),
      .req_sda_level    (req_sda_level),
      .req_drive_sda    (req_drive_sda),
      .req_load_address (req_load_address),
      .req_load_data    (req_load_data),
      .csr_valid        (csr_valid),
      .csr_address_mask (csr_address_mask),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_sda_line     (rsp_sda_line),
      .rsp_scl_echo     (rsp_scl_echo),
      .rsp_byte_stored  (rsp_byte_stored)
   );

   i2cee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* hw/rtl/i2cee_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module i2cee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/i2cee_ctrl.sv */
// Sequencing controller: clearing sweep, item accept, memory fetch, update.
// Depends on i2cee_pkg.
module i2cee_ctrl import i2cee_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
         valid_ff <= (state_ff == ST_EXEC);
      end
   end

   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign busy        = busy_ff;
   assign rsp_valid   = valid_ff;

endmodule

/* hw/rtl/i2cee_datapath.sv */
// Bus state, shift logic, address counter, memory port control and results.
// Depends on i2cee_pkg; drives the ports of an i2cee_ram instance.
module i2cee_datapath import i2cee_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status,
   input  logic [1:0]          req_opcode,
   input  logic                req_scl_level,
   input  logic                req_sda_level,
   input  logic                req_drive_sda,
   input  logic [WORD_W-1:0]   req_load_address,
   input  logic [DATA_W-1:0]   req_load_data,
   input  logic                csr_valid,
   input  logic [WORD_W-1:0]   csr_address_mask,
   output logic                ram_wr_en,
   output logic [ADDR_W-1:0]   ram_wr_addr,
   output logic [DATA_W-1:0]   ram_wr_data,
   output logic [ADDR_W-1:0]   ram_rd_addr,
   input  logic [DATA_W-1:0]   ram_rd_data,
   output logic                rsp_sda_line,
   output logic                rsp_scl_echo,
   output logic                rsp_byte_stored
);

   logic [WORD_W-1:0] mask_ff;
   logic [ADDR_W-1:0] clr_count_ff;

   logic [1:0]        opcode_ff;
   logic              scl_ff, sda_ff, drive_ff;
   logic [WORD_W-1:0] load_addr_ff;
   logic [DATA_W-1:0] load_data_ff;

   logic              active_ff, active_in;
   logic [1:0]        phase_ff, phase_in;
   logic [3:0]        bit_idx_ff, bit_idx_in;
   logic [7:0]        shift_ff, shift_in;
   logic              read_mode_ff, read_mode_in;
   logic              ack_clk_ff, ack_clk_in;
   logic              master_acks_ff, master_acks_in;
   logic [2:0]        page_ff, page_in;
   logic [WORD_W-1:0] word_addr_ff, word_addr_in;
   logic              read_bit_ff, read_bit_in;
   logic              prev_scl_ff, prev_scl_in;
   logic              prev_sda_ff, prev_sda_in;
   logic              drives_ff, drives_in;

   logic              sda_line_ff, sda_line_in;
   logic              scl_echo_ff;
   logic              stored_ff, stored_in;

   logic              exec_we;
   logic [ADDR_W-1:0] exec_addr;
   logic [DATA_W-1:0] exec_data;

   always_comb begin
      logic long_addr;
      logic mcu;
      logic eep;
      logic [2:0] bit_sel;

      active_in      = active_ff;
      phase_in       = phase_ff;
      bit_idx_in     = bit_idx_ff;
      shift_in       = shift_ff;
      read_mode_in   = read_mode_ff;
      ack_clk_in     = ack_clk_ff;
      master_acks_in = master_acks_ff;
      page_in        = page_ff;
      word_addr_in   = word_addr_ff;
      read_bit_in    = read_bit_ff;
      prev_scl_in    = prev_scl_ff;
      prev_sda_in    = prev_sda_ff;
      drives_in      = drives_ff;
      stored_in      = 1'b0;
      exec_we        = 1'b0;
      exec_addr      = mem_index(word_addr_ff, mask_ff);
      exec_data      = shift_ff;
      long_addr      = (mask_ff > ONE_BYTE_MAX);
      bit_sel        = 3'(3'd7 - bit_idx_ff[2:0]);

      case (opcode_type'(opcode_ff))
         OP_PIN: begin
            if (drives_ff && scl_ff && prev_scl_ff) begin
               if (prev_sda_ff && !sda_ff) begin
                  active_in      = 1'b1;
                  phase_in       = PH_DEVICE;
                  bit_idx_in     = 4'd0;
                  shift_in       = 8'd0;
                  read_mode_in   = 1'b0;
                  ack_clk_in     = 1'b0;
                  master_acks_in = 1'b0;
               end else if (!prev_sda_ff && sda_ff) begin
                  active_in = 1'b0;
               end
            end
            if (active_in && scl_ff && !prev_scl_ff) begin
               if (ack_clk_in) begin
                  if (bit_idx_in == 4'd8) bit_idx_in = 4'd9;
               end else if (bit_idx_in < 4'd8) begin
                  if (read_mode_in && phase_in == PH_DATA) begin
                     read_bit_in = ram_rd_data[bit_sel];
                  end else begin
                     shift_in = {shift_in[6:0], sda_ff};
                  end
                  bit_idx_in = 4'(bit_idx_in + 4'd1);
                  if (bit_idx_in == 4'd8) begin
                     master_acks_in = read_mode_in && (phase_in == PH_DATA);
                     ack_clk_in     = 1'b1;
                     if (!master_acks_in) begin
                        case (phase_in)
                           PH_DEVICE: begin
                              page_in      = shift_in[3:1];
                              read_mode_in = shift_in[0];
                              if (shift_in[0]) begin
                                 if (!long_addr) begin
                                    word_addr_in = {2'b00, shift_in[3:1], word_addr_in[7:0]};
                                 end
                                 phase_in = PH_DATA;
                              end else begin
                                 phase_in = PH_WORD;
                              end
                           end
                           PH_WORD: begin
                              if (long_addr) begin
                                 word_addr_in = {shift_in[4:0], 8'd0};
                                 phase_in     = PH_LOW;
                              end else begin
                                 word_addr_in = {2'b00, page_in, shift_in};
                                 phase_in     = PH_DATA;
                              end
                           end
                           PH_LOW: begin
                              word_addr_in = {word_addr_in[12:8], shift_in};
                              phase_in     = PH_DATA;
                           end
                           default: begin
                              exec_we      = 1'b1;
                              exec_addr    = mem_index(word_addr_in, mask_ff);
                              exec_data    = shift_in;
                              word_addr_in = (word_addr_in + 13'd1) & mask_ff;
                              stored_in    = 1'b1;
                           end
                        endcase
                     end
                  end
               end
            end
            if (active_in && !scl_ff && prev_scl_ff && bit_idx_in == 4'd9) begin
               if (master_acks_in) begin
                  if (sda_ff) active_in = 1'b0;
                  else word_addr_in = (word_addr_in + 13'd1) & mask_ff;
               end
               ack_clk_in = 1'b0;
               bit_idx_in = 4'd0;
            end
            prev_scl_in = scl_ff;
            prev_sda_in = sda_ff;
         end
         OP_DIR: drives_in = drive_ff;
         OP_LOAD: begin
            exec_we   = 1'b1;
            exec_addr = mem_index(load_addr_ff, {WORD_W{1'b1}});
            exec_data = load_data_ff;
         end
         default: ;
      endcase

      mcu = !(drives_in && !prev_sda_in);
      eep = 1'b1;
      if (active_in) begin
         if (read_mode_in && phase_in == PH_DATA && bit_idx_in <= 4'd8) eep = read_bit_in;
         else if (ack_clk_in) eep = master_acks_in;
      end
      sda_line_in = mcu & eep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= MASK_RESET;
         clr_count_ff   <= '0;
         active_ff      <= 1'b0;
         phase_ff       <= PH_DEVICE;
         bit_idx_ff     <= 4'd0;
         shift_ff       <= 8'd0;
         read_mode_ff   <= 1'b0;
         ack_clk_ff     <= 1'b0;
         master_acks_ff <= 1'b0;
         page_ff        <= 3'd0;
         word_addr_ff   <= '0;
         read_bit_ff    <= 1'b0;
         prev_scl_ff    <= 1'b0;
         prev_sda_ff    <= 1'b0;
         drives_ff      <= 1'b1;
      end else begin
         if (csr_valid) mask_ff <= csr_address_mask;
         if (cmd.clear) clr_count_ff <= ADDR_W'(clr_count_ff + 1'b1);
         if (cmd.execute) begin
            active_ff      <= active_in;
            phase_ff       <= phase_in;
            bit_idx_ff     <= bit_idx_in;
            shift_ff       <= shift_in;
            read_mode_ff   <= read_mode_in;
            ack_clk_ff     <= ack_clk_in;
            master_acks_ff <= master_acks_in;
            page_ff        <= page_in;
            word_addr_ff   <= word_addr_in;
            read_bit_ff    <= read_bit_in;
            prev_scl_ff    <= prev_scl_in;
            prev_sda_ff    <= prev_sda_in;
            drives_ff      <= drives_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff    <= req_opcode;
         scl_ff       <= req_scl_level;
         sda_ff       <= req_sda_level;
         drive_ff     <= req_drive_sda;
         load_addr_ff <= req_load_address;
         load_data_ff <= req_load_data;
      end
      if (cmd.execute) begin
         sda_line_ff <= sda_line_in;
         scl_echo_ff <= prev_scl_in;
         stored_ff   <= stored_in;
      end
   end

   assign status.clear_last = &clr_count_ff;

   assign ram_rd_addr = mem_index(word_addr_ff, mask_ff);
   assign ram_wr_en   = cmd.clear || (cmd.execute && exec_we);
   assign ram_wr_addr = cmd.clear ? clr_count_ff : exec_addr;
   assign ram_wr_data = cmd.clear ? ERASED_BYTE : exec_data;

   assign rsp_sda_line    = sda_line_ff;
   assign rsp_scl_echo    = scl_echo_ff;
   assign rsp_byte_stored = stored_ff;

endmodule

/* tb/tb_i2c_eeprom_slave_unit.sv */
// Self-checking testbench for the I2C EEPROM slave unit: bit-banged bus traffic,
// preloads and line reads, each result checked against an in-bench EEPROM model.
// Depends on i2cee_pkg and the i2c_eeprom_slave_unit RTL.
`timescale 1ns / 1ps

module tb_i2c_eeprom_slave_unit;
   import i2cee_pkg::*;

   localparam int CYCLE_LIMIT     = 250000;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int PHASES          = 7;

   typedef struct packed {
      opcode_type          opcode;
      logic                scl;
      logic                sda;
      logic                drive;
      logic [WORD_W-1:0]   load_addr;
      logic [DATA_W-1:0]   load_byte;
   } bus_access_type;

   typedef struct packed {
      logic sda_line;
      logic scl_echo;
      logic byte_stored;
   } line_status_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   bus_access_type      cur_access = '0;
   logic                rsp_valid;
   logic                rsp_sda_line;
   logic                rsp_scl_echo;
   logic                rsp_byte_stored;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WORD_W-1:0]   csr_address_mask = MASK_RESET;

   bus_access_type      pending_accesses[$];
   line_status_type     line_status_due[$];
   int                  hold_cycles = 0;
   logic                steady_run = 1'b0;
   int                  queued_items = 0;
   int                  mismatches = 0;
   int                  cycle_count = 0;
   logic [WORD_W-1:0]   phase_mask = MASK_RESET;

   // EEPROM model state
   logic [DATA_W-1:0]   eeprom_mem [MEM_BYTES];
   logic [WORD_W-1:0]   model_mask = MASK_RESET;
   logic                in_transfer = 1'b0;
   logic [1:0]          phase = PH_DEVICE;
   logic [3:0]          bit_cnt = '0;
   logic [7:0]          shreg = '0;
   logic                reading = 1'b0;
   logic                in_ack = 1'b0;
   logic                host_acks = 1'b0;
   logic [2:0]          page_sel = '0;
   logic [WORD_W-1:0]   waddr = '0;
   logic                out_bit = 1'b0;
   logic                last_scl = 1'b0;
   logic                last_sda = 1'b0;
   logic                host_drives = 1'b1;

   i2c_eeprom_slave_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (cur_access.opcode),
      .req_scl_level    (cur_access.scl),
      .req_sda_level    (cur_access.sda),
      .req_drive_sda    (cur_access.drive),
      .req_load_address (cur_access.load_addr),
      .req_load_data    (cur_access.load_byte),
      .rsp_valid        (rsp_valid),
      .rsp_sda_line     (rsp_sda_line),
      .rsp_scl_echo     (rsp_scl_echo),
      .rsp_byte_stored  (rsp_byte_stored),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_address_mask (csr_address_mask)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic line_status_type line_status_after(input bus_access_type a);
      line_status_type st;
      logic [7:0]      cur;
      logic            wrote;
      logic            eep;
      wrote = 1'b0;
      case (a.opcode)
         OP_PIN: begin
            if (host_drives && a.scl && last_scl) begin
               if (last_sda && !a.sda) begin
                  in_transfer = 1'b1;
                  phase       = PH_DEVICE;
                  bit_cnt     = '0;
                  shreg       = '0;
                  reading     = 1'b0;
                  in_ack      = 1'b0;
                  host_acks   = 1'b0;
               end else if (!last_sda && a.sda) begin
                  in_transfer = 1'b0;
               end
            end
            if (in_transfer && a.scl && !last_scl) begin
               if (in_ack) begin
                  if (bit_cnt == 4'd8) bit_cnt = 4'd9;
               end else if (bit_cnt < 4'd8) begin
                  if (reading && phase == PH_DATA) begin
                     cur     = eeprom_mem[waddr & model_mask];
                     out_bit = cur[3'd7 - bit_cnt[2:0]];
                  end else begin
                     shreg = {shreg[6:0], a.sda};
                  end
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt == 4'd8) begin
                     host_acks = reading && phase == PH_DATA;
                     in_ack    = 1'b1;
                     if (!host_acks) begin
                        case (phase)
                           PH_DEVICE: begin
                              page_sel = shreg[3:1];
                              reading  = shreg[0];
                              if (reading) begin
                                 if (model_mask <= ONE_BYTE_MAX)
                                    waddr = {2'b00, page_sel, waddr[7:0]};
                                 phase = PH_DATA;
                              end else begin
                                 phase = PH_WORD;
                              end
                           end
                           PH_WORD: begin
                              if (model_mask > ONE_BYTE_MAX) begin
                                 waddr = {shreg[4:0], 8'h00};
                                 phase = PH_LOW;
                              end else begin
                                 waddr = {2'b00, page_sel, shreg};
                                 phase = PH_DATA;
                              end
                           end
                           PH_LOW: begin
                              waddr = {waddr[12:8], shreg};
                              phase = PH_DATA;
                           end
                           default: begin
                              eeprom_mem[waddr & model_mask] = shreg;
                              waddr = (waddr + 1'b1) & model_mask;
                              wrote = 1'b1;
                           end
                        endcase
                     end
                  end
               end
            end
            if (in_transfer && !a.scl && last_scl && bit_cnt == 4'd9) begin
               if (host_acks) begin
                  if (a.sda) in_transfer = 1'b0;
                  else waddr = (waddr + 1'b1) & model_mask;
               end
               in_ack  = 1'b0;
               bit_cnt = '0;
            end
            last_scl = a.scl;
            last_sda = a.sda;
         end
         OP_DIR:  host_drives = a.drive;
         OP_LOAD: eeprom_mem[a.load_addr] = a.load_byte;
         default: ;
      endcase
      eep = 1'b1;
      if (in_transfer) begin
         if (reading && phase == PH_DATA && bit_cnt <= 4'd8) eep = out_bit;
         else if (in_ack) eep = host_acks;
      end
      st.sda_line    = !(host_drives && !last_sda) & eep;
      st.scl_echo    = last_scl;
      st.byte_stored = wrote;
      return st;
   endfunction

   always @(posedge clock) begin : driver
      bus_access_type nxt;
      logic           taken;
      if (reset) begin
         start       <= 1'b0;
         hold_cycles <= 0;
      end else begin
         taken = start && !busy;
         if (taken) line_status_due.push_back(line_status_after(cur_access));
         if (!start || taken) begin
            if (hold_cycles != 0) begin
               hold_cycles <= hold_cycles - 1;
               start       <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               nxt = pending_accesses.pop_front();
               cur_access  <= nxt;
               start       <= 1'b1;
               hold_cycles <= steady_run ? 0 : int'($urandom_range(0, 13));
               if ($urandom_range(0, 39) == 0) steady_run <= !steady_run;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      line_status_type want;
      if (!reset && rsp_valid) begin
         if (line_status_due.size() == 0) begin
            $error("result with none due: sda_line %0b scl_echo %0b byte_stored %0b",
                   rsp_sda_line, rsp_scl_echo, rsp_byte_stored);
            mismatches++;
         end else begin
            want = line_status_due.pop_front();
            if (rsp_sda_line !== want.sda_line) begin
               $error("sda_line: expected %0b, actual %0b", want.sda_line, rsp_sda_line);
               mismatches++;
            end
            if (rsp_scl_echo !== want.scl_echo) begin
               $error("scl_echo: expected %0b, actual %0b", want.scl_echo, rsp_scl_echo);
               mismatches++;
            end
            if (rsp_byte_stored !== want.byte_stored) begin
               $error("byte_stored: expected %0b, actual %0b",
                      want.byte_stored, rsp_byte_stored);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_i2c_eeprom_slave_unit: FAIL");
         $finish;
      end
   end

   function automatic bus_access_type rand_access();
      bus_access_type a;
      a.opcode    = opcode_type'($urandom_range(0, 3));
      a.scl       = 1'($urandom_range(0, 1));
      a.sda       = 1'($urandom_range(0, 1));
      a.drive     = 1'($urandom_range(0, 1));
      a.load_addr = WORD_W'($urandom_range(0, MEM_BYTES - 1));
      a.load_byte = DATA_W'($urandom_range(0, 255));
      return a;
   endfunction

   function automatic logic [WORD_W-1:0] pick_address();
      case ($urandom_range(0, 2))
         0:       return WORD_W'($urandom_range(0, MEM_BYTES - 1));
         1:       return WORD_W'($urandom_range(0, 47));
         default: return WORD_W'(phase_mask - $urandom_range(0, 8));
      endcase
   endfunction

   task automatic put(input bus_access_type a);
      pending_accesses.push_back(a);
      queued_items++;
   endtask

   task automatic put_pin(input logic scl, input logic sda);
      bus_access_type a;
      a        = rand_access();
      a.opcode = OP_PIN;
      a.scl    = scl;
      a.sda    = sda;
      put(a);
   endtask

   task automatic put_dir(input logic drive);
      bus_access_type a;
      a        = rand_access();
      a.opcode = OP_DIR;
      a.drive  = drive;
      put(a);
   endtask

   task automatic put_probe();
      bus_access_type a;
      a        = rand_access();
      a.opcode = OP_READ;
      put(a);
   endtask

   task automatic put_load(input logic [WORD_W-1:0] addr, input logic [DATA_W-1:0] data);
      bus_access_type a;
      a           = rand_access();
      a.opcode    = OP_LOAD;
      a.load_addr = addr;
      a.load_byte = data;
      put(a);
   endtask

   task automatic put_start();
      put_pin(1'b0, 1'b1);
      put_pin(1'b1, 1'b1);
      put_pin(1'b1, 1'b0);
      put_pin(1'b0, 1'b0);
   endtask

   task automatic put_stop();
      put_pin(1'b0, 1'b0);
      put_pin(1'b1, 1'b0);
      put_pin(1'b1, 1'b1);
   endtask

   // Master sends a byte, then releases SDA for the slave acknowledge.
   task automatic send_byte(input logic [7:0] b);
      logic rel;
      logic x;
      for (int i = 7; i >= 0; i--) begin
         put_pin(1'b0, b[i]);
         put_pin(1'b1, b[i]);
         if ($urandom_range(0, 5) == 0) put_probe();
      end
      rel = ($urandom_range(0, 2) == 0);
      x   = rel ? 1'($urandom_range(0, 1)) : 1'b1;
      put_pin(1'b0, x);
      if (rel) put_dir(1'b0);
      put_pin(1'b1, x);
      put_probe();
      put_pin(1'b0, x);
      if (rel) put_dir(1'b1);
   endtask

   // Master clocks in a byte, then answers with ack_bit (0 ack, 1 nack).
   task automatic recv_byte(input logic ack_bit);
      logic rel;
      logic r;
      rel = ($urandom_range(0, 2) == 0);
      if (rel) put_dir(1'b0);
      for (int i = 0; i < 8; i++) begin
         r = rel ? 1'($urandom_range(0, 1)) : 1'b1;
         put_pin(1'b0, r);
         put_pin(1'b1, r);
         if ($urandom_range(0, 2) == 0) put_probe();
      end
      if (rel) put_dir(1'b1);
      put_pin(1'b0, ack_bit);
      put_pin(1'b1, ack_bit);
      put_probe();
      put_pin(1'b0, ack_bit);
   endtask

   task automatic send_word_address(input logic [WORD_W-1:0] wa);
      if (phase_mask > ONE_BYTE_MAX) send_byte({3'($urandom_range(0, 7)), wa[12:8]});
      send_byte(wa[7:0]);
   endtask

   function automatic logic [3:0] device_code();
      return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hA;
   endfunction

   initial begin : stimulus
      logic [WORD_W-1:0] masks [PHASES];
      logic [WORD_W-1:0] wa;
      int                goal;
      int                n;
      masks[0] = MASK_RESET;
      masks[1] = 13'h1FFF;
      masks[2] = 13'd2048;
      masks[3] = 13'h00FF;
      masks[4] = 13'h0FFF;
      masks[5] = WORD_W'($urandom_range(2047, 8191));
      masks[6] = 13'h0000;
      for (int i = 0; i < MEM_BYTES; i++) eeprom_mem[i] = ERASED_BYTE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         @(posedge clock);
         csr_valid        <= 1'b1;
         csr_address_mask <= masks[p];
         do @(posedge clock); while (!csr_ready);
         csr_valid  <= 1'b0;
         model_mask  = masks[p];
         phase_mask  = masks[p];
         @(negedge clock);

         if (p == 0) begin
            put_probe();
            put_load(13'h0000, 8'h00);
            put_load(13'h1FFF, 8'hFF);
            put_load(13'h0AAA, 8'h55);
            // bus conditions must be ignored while SDA is released
            put_dir(1'b0);
            put_pin(1'b1, 1'b1);
            put_pin(1'b1, 1'b0);
            put_pin(1'b1, 1'b1);
            put_dir(1'b1);
            put_start();
            put_pin(1'b0, 1'b1);
            put_pin(1'b1, 1'b1);
            put_pin(1'b0, 1'b0);
            put_pin(1'b1, 1'b0);
            // restart part way through the device byte
            put_pin(1'b0, 1'b1);
            put_pin(1'b1, 1'b1);
            put_pin(1'b1, 1'b0);
            put_stop();
         end

         goal = queued_items + ITEMS_PER_PHASE;
         while (queued_items < goal) begin
            wa = pick_address();
            case ($urandom_range(0, 99)) inside
               [0:29]: begin
                  put_start();
                  send_byte({device_code(), wa[10:8], 1'b0});
                  send_word_address(wa);
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
                  put_stop();
               end
               [30:54]: begin
                  put_start();
                  send_byte({device_code(), wa[10:8], 1'b0});
                  send_word_address(wa);
                  put_start();
                  send_byte({device_code(), wa[10:8], 1'b1});
                  n = $urandom_range(1, 5);
                  for (int i = 1; i < n; i++) recv_byte(1'b0);
                  recv_byte(1'b1);
                  put_stop();
               end
               [55:69]: begin
                  put_start();
                  send_byte({device_code(), 3'($urandom_range(0, 7)), 1'b1});
                  n = $urandom_range(1, 4);
                  for (int i = 1; i < n; i++) recv_byte(1'b0);
                  recv_byte(1'b1);
                  put_stop();
               end
               [70:77]: begin
                  n = $urandom_range(1, 4);
                  for (int i = 0; i < n; i++)
                     put_load(pick_address(), 8'($urandom_range(0, 255)));
               end
               [78:89]: begin
                  // broken transfer: the next start or stop cuts it short
                  put_start();
                  n = $urandom_range(1, 20);
                  for (int i = 0; i < n; i++) begin
                     wa[0] = 1'($urandom_range(0, 1));
                     put_pin(1'b0, wa[0]);
                     put_pin(1'b1, wa[0]);
                  end
                  if ($urandom_range(0, 1) == 0) put_stop();
               end
               default: begin
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++) put(rand_access());
                  put_dir(1'b1);
               end
            endcase
         end

         do @(negedge clock);
         while (pending_accesses.size() != 0 || start || line_status_due.size() != 0);
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb_i2c_eeprom_slave_unit: PASS");
      else
         $display("tb_i2c_eeprom_slave_unit: FAIL");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_ram.sv
hw/rtl/i2cee_ctrl.sv
hw/rtl/i2cee_datapath.sv
hw/rtl/i2c_eeprom_slave_unit.sv
tb/tb_i2c_eeprom_slave_unit.sv
